/* hdl/acfp_pkg.sv */
// ----------------------------------------------------------------------------
// acfp_pkg
// Types, character codes and digit helpers for the ASCII command frame
// processor.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int MAX_FRAME = 16;
  localparam int CNT_W     = $clog2(MAX_FRAME - 1);

  localparam logic [7:0] CH_SOF  = 8'h23;  // '#'
  localparam logic [7:0] CH_EOF  = 8'h21;  // '!'
  localparam logic [7:0] CH_E    = 8'h45;  // 'E'
  localparam logic [7:0] CH_OK   = 8'h6f;  // 'o'
  localparam logic [7:0] CH_UNK  = 8'h69;  // 'i'
  localparam logic [7:0] CH_SUM  = 8'h73;  // 's'
  localparam logic [7:0] CH_FRM  = 8'h66;  // 'f'
  localparam logic [7:0] CH_TEMP = 8'h63;  // 'c'
  localparam logic [7:0] CH_MAX  = 8'h4d;  // 'M'
  localparam logic [7:0] CH_CUR  = 8'h43;  // 'C'
  localparam logic [7:0] CH_BAND = 8'h53;  // 'S'
  localparam logic [7:0] CH_PLUS = 8'h2b;  // '+'
  localparam logic [7:0] CH_MIN  = 8'h2d;  // '-'
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNK   = 2'd1,
    ST_CSUM  = 2'd2,
    ST_FRAME = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]        rx_byte;
    logic signed [7:0] sensor_temp;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] reply_status;
    logic [9:0] temp_limit;
    logic [6:0] half_band;
  } out_item_t;

  // three decimal digits {hundreds, tens, ones} of an 8-bit value
  function automatic logic [11:0] dec3(input logic [7:0] v);
    logic [13:0] ph;
    logic [3:0]  h;
    logic [7:0]  r;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  o;
    ph = {6'd0, v} * 14'd41;
    h  = {2'd0, ph[13:12]};
    r  = v - ({4'd0, h} * 8'd100);
    pt = {7'd0, r} * 15'd205;
    t  = pt[14:11];
    o  = 4'(r - ({4'd0, t} * 8'd10));
    return {h, t, o};
  endfunction

  function automatic logic [7:0] dig_ch(input logic [3:0] d);
    return {4'h3, d};
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c inside {[CH_0:CH_9]});
  endfunction

endpackage

/* hdl/ascii_command_frame_processor.sv */
// ----------------------------------------------------------------------------
// ascii_command_frame_processor
// Latency: a request is decoded while it sits in the input register; the
// first reply byte is offered on the next cycle.
// Replies are 7 or 9 bytes, one per cycle while tx_ready is high.
// Throughput: one request per cycle while no reply is pending; during a reply
// one request is buffered and the next waits for the reply's last byte.
// Reset (rst, synchronous) closes any frame and clears both settings.
// ----------------------------------------------------------------------------
module ascii_command_frame_processor import acfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_ready,
  input  in_item_t  rx_data,
  output logic      tx_valid,
  input  logic      tx_ready,
  output out_item_t tx_data
);

  // input register
  logic     in_full;
  in_item_t in_q;

  // frame state
  logic             in_frame;
  logic [CNT_W-1:0] frame_count;
  logic [7:0]       payload_sum;
  logic [7:0]       lag_bytes [3];
  logic [7:0]       head_bytes [4];
  logic [9:0]       temp_limit_reg;
  logic [6:0]       half_band_reg;

  // reply buffer
  logic       rpl_valid;
  logic [3:0] rpl_idx;
  logic       rpl_long;
  logic [7:0] rpl_body [4];
  status_t    rpl_status;
  logic [9:0] rpl_max;
  logic [6:0] rpl_half;

  logic tx_fire;
  logic tx_last;
  logic advance;

  assign tx_fire  = tx_valid && tx_ready;
  assign advance  = in_full && (!rpl_valid || (tx_fire && tx_last));
  assign rx_ready = !in_full || advance;

  // request decode
  logic [7:0]  b;
  logic        is_close;
  logic        is_over;
  logic        need_reply;
  status_t     rp_status;
  logic        rp_long;
  logic [7:0]  rp_body [4];
  logic [9:0]  max_next;
  logic [6:0]  half_next;
  logic [11:0] sum_dig;
  logic [CNT_W-1:0] plen;
  logic        v1, v2, v3;
  logic [3:0]  d1, d2, d3;
  logic [9:0]  val2, val3;
  logic signed [7:0] ts;
  logic [6:0]  mag;
  logic [14:0] pm;
  logic [3:0]  mt, mo;

  always_comb begin
    b          = in_q.rx_byte;
    is_close   = in_frame && (b == CH_EOF);
    is_over    = in_frame && (b != CH_EOF) && (frame_count >= CNT_W'(MAX_FRAME - 2));
    need_reply = is_close || is_over;
    sum_dig    = dec3(payload_sum);
    plen       = frame_count - CNT_W'(3);

    d1 = head_bytes[1][3:0];
    d2 = head_bytes[2][3:0];
    d3 = head_bytes[3][3:0];
    v1 = (plen > CNT_W'(1)) && is_dig(head_bytes[1]);
    v2 = v1 && (plen > CNT_W'(2)) && is_dig(head_bytes[2]);
    v3 = v2 && (plen > CNT_W'(3)) && is_dig(head_bytes[3]);
    val2 = !v1 ? 10'd0 : (!v2 ? {6'd0, d1} : ({6'd0, d1} * 10'd10 + {6'd0, d2}));
    val3 = v3 ? ({6'd0, d1} * 10'd100 + {6'd0, d2} * 10'd10 + {6'd0, d3}) : val2;

    ts = in_q.sensor_temp;
    if (ts > 8'sd99) begin
      ts = 8'sd99;
    end else if (ts < -8'sd99) begin
      ts = -8'sd99;
    end
    mag = ts[7] ? 7'(-ts) : ts[6:0];
    pm  = {8'd0, mag} * 15'd205;
    mt  = pm[14:11];
    mo  = 4'(mag - ({3'd0, mt} * 7'd10));

    max_next   = temp_limit_reg;
    half_next  = half_band_reg;
    rp_status  = ST_OK;
    rp_long    = 1'b0;
    rp_body[0] = CH_E;
    rp_body[1] = CH_OK;
    rp_body[2] = 8'd0;
    rp_body[3] = 8'd0;

    if (is_over) begin
      rp_status  = ST_FRAME;
      rp_body[1] = CH_FRM;
    end else if (frame_count < CNT_W'(3) ||
                 lag_bytes[0] != dig_ch(sum_dig[11:8]) ||
                 lag_bytes[1] != dig_ch(sum_dig[7:4]) ||
                 lag_bytes[2] != dig_ch(sum_dig[3:0])) begin
      rp_status  = ST_CSUM;
      rp_body[1] = CH_SUM;
    end else if (plen == '0) begin
      rp_status  = ST_UNK;
      rp_body[1] = CH_UNK;
    end else begin
      case (head_bytes[0])
        CH_MAX: begin
          max_next = val3;
        end
        CH_BAND: begin
          half_next = val2[6:0];
        end
        CH_CUR: begin
          rp_long    = 1'b1;
          rp_body[0] = CH_TEMP;
          rp_body[1] = ts[7] ? CH_MIN : CH_PLUS;
          rp_body[2] = dig_ch(mt);
          rp_body[3] = dig_ch(mo);
        end
        default: begin
          rp_status  = ST_UNK;
          rp_body[1] = CH_UNK;
        end
      endcase
    end
    if (!is_close) begin
      max_next  = temp_limit_reg;
      half_next = half_band_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_ready) begin
      in_full <= rx_valid;
    end
    if (rx_valid && rx_ready) begin
      in_q <= rx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      frame_count    <= '0;
      payload_sum    <= 8'd0;
      temp_limit_reg <= 10'd0;
      half_band_reg  <= 7'd0;
    end else if (advance) begin
      temp_limit_reg <= max_next;
      half_band_reg  <= half_next;
      if (!in_frame) begin
        if (b == CH_SOF) begin
          in_frame    <= 1'b1;
          frame_count <= '0;
          payload_sum <= 8'd0;
        end
      end else if (need_reply) begin
        in_frame <= 1'b0;
      end else begin
        if (frame_count >= CNT_W'(3)) begin
          payload_sum <= payload_sum + lag_bytes[0];
        end
        frame_count <= frame_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_frame && !need_reply) begin
      lag_bytes[0] <= lag_bytes[1];
      lag_bytes[1] <= lag_bytes[2];
      lag_bytes[2] <= b;
      if (frame_count < CNT_W'(4)) begin
        head_bytes[frame_count[1:0]] <= b;
      end
    end
  end

  // reply buffer and serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      rpl_valid <= 1'b0;
      rpl_idx   <= 4'd0;
    end else if (advance && need_reply) begin
      rpl_valid <= 1'b1;
      rpl_idx   <= 4'd0;
    end else if (tx_fire) begin
      if (tx_last) begin
        rpl_valid <= 1'b0;
      end else begin
        rpl_idx <= rpl_idx + 4'd1;
      end
    end
    if (advance && need_reply) begin
      rpl_long   <= rp_long;
      rpl_body   <= rp_body;
      rpl_status <= rp_status;
      rpl_max    <= max_next;
      rpl_half   <= half_next;
    end
  end

  logic [7:0]  body_sum;
  logic [11:0] rsum_dig;
  logic [3:0]  last_idx;
  logic [3:0]  dig_base;
  logic [7:0]  tx_ch;

  always_comb begin
    body_sum = rpl_body[0] + rpl_body[1] + rpl_body[2] + rpl_body[3];
    rsum_dig = dec3(body_sum);
    last_idx = rpl_long ? 4'd8 : 4'd6;
    dig_base = rpl_long ? 4'd5 : 4'd3;
    tx_last  = (rpl_idx == last_idx);
    if (rpl_idx == 4'd0) begin
      tx_ch = CH_SOF;
    end else if (rpl_idx < dig_base) begin
      tx_ch = rpl_body[2'(rpl_idx - 4'd1)];
    end else if (rpl_idx == dig_base) begin
      tx_ch = dig_ch(rsum_dig[11:8]);
    end else if (rpl_idx == dig_base + 4'd1) begin
      tx_ch = dig_ch(rsum_dig[7:4]);
    end else if (rpl_idx == dig_base + 4'd2) begin
      tx_ch = dig_ch(rsum_dig[3:0]);
    end else begin
      tx_ch = CH_EOF;
    end
  end

  assign tx_valid             = rpl_valid;
  assign tx_data.tx_byte      = tx_ch;
  assign tx_data.last         = tx_last;
  assign tx_data.reply_status = rpl_status;
  assign tx_data.temp_limit   = rpl_max;
  assign tx_data.half_band    = rpl_half;

endmodule

/* dv/tb_ascii_command_frame_processor.sv */
// ----------------------------------------------------------------------------
// tb_ascii_command_frame_processor
// Sends received bytes (command frames, corrupt and overlong frames, line
// noise) into the frame processor and checks every reply byte against a
// behavioral predictor. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ascii_command_frame_processor;
  import acfp_pkg::*;

  localparam int ITEMS       = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 20;

  typedef enum int {
    CMD_MAX,
    CMD_BAND,
    CMD_TEMP,
    CMD_OTHER,
    CMD_EMPTY
  } cmd_kind_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_ready;
  in_item_t  rx_data = '0;
  logic      tx_valid;
  logic      tx_ready = 1'b0;
  out_item_t tx_data;

  ascii_command_frame_processor dut (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_data  (rx_data),
    .tx_valid (tx_valid),
    .tx_ready (tx_ready),
    .tx_data  (tx_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic       frame_open = 1'b0;
  int         frame_len = 0;
  logic [7:0] body_sum = '0;
  logic [7:0] tail_bytes [3] = '{default: '0};
  logic [7:0] lead_bytes [4] = '{default: '0};
  logic [9:0] max_setting = '0;
  logic [6:0] band_setting = '0;

  out_item_t  reply_bytes_q [$];
  in_item_t   request_q [$];
  logic [7:0] body_q [$];

  int errors = 0;
  int rx_count = 0;
  int request_total = 0;
  int frame_bytes = 0;
  int cycle_count = 0;
  logic rx_took = 1'b0;
  int rx_gap = 0;
  int tx_stall = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;

  function automatic logic [7:0] ascii_digit(input int v);
    return CH_0 + 8'(v);
  endfunction

  task automatic push_reply(input logic [31:0] body, input int n, input status_t st);
    logic [7:0] msg [$];
    logic [7:0] sum;
    out_item_t  r;
    int         i;
    sum = '0;
    msg.push_back(CH_SOF);
    for (i = 0; i < n; i++) begin
      msg.push_back(body[31-8*i -: 8]);
      sum += body[31-8*i -: 8];
    end
    msg.push_back(ascii_digit(sum / 100));
    msg.push_back(ascii_digit((sum / 10) % 10));
    msg.push_back(ascii_digit(sum % 10));
    msg.push_back(CH_EOF);
    foreach (msg[k]) begin
      r.tx_byte      = msg[k];
      r.last         = (k == msg.size() - 1);
      r.reply_status = st;
      r.temp_limit   = max_setting;
      r.half_band    = band_setting;
      reply_bytes_q.push_back(r);
    end
  endtask

  task automatic push_code(input logic [7:0] code, input status_t st);
    push_reply({CH_E, code, 16'h0}, 2, st);
  endtask

  function automatic int read_number(input int plen, input int ndig);
    int val;
    int i;
    val = 0;
    for (i = 1; i <= ndig; i++) begin
      if (i >= plen || lead_bytes[i] < CH_0 || lead_bytes[i] > ascii_digit(9)) break;
      val = val * 10 + int'(lead_bytes[i] - CH_0);
    end
    return val;
  endfunction

  task automatic close_frame(input logic signed [7:0] temp);
    int plen;
    int t;
    int mag;
    frame_open = 1'b0;
    if (frame_len < 3) begin
      push_code(CH_SUM, ST_CSUM);
    end else if (tail_bytes[0] != ascii_digit(body_sum / 100) ||
                 tail_bytes[1] != ascii_digit((body_sum / 10) % 10) ||
                 tail_bytes[2] != ascii_digit(body_sum % 10)) begin
      push_code(CH_SUM, ST_CSUM);
    end else begin
      plen = frame_len - 3;
      if (plen == 0) begin
        push_code(CH_UNK, ST_UNK);
      end else if (lead_bytes[0] == CH_MAX) begin
        max_setting = 10'(read_number(plen, 3));
        push_code(CH_OK, ST_OK);
      end else if (lead_bytes[0] == CH_BAND) begin
        band_setting = 7'(read_number(plen, 2));
        push_code(CH_OK, ST_OK);
      end else if (lead_bytes[0] == CH_CUR) begin
        t = temp;
        if (t > 99) t = 99;
        if (t < -99) t = -99;
        mag = (t < 0) ? -t : t;
        push_reply({CH_TEMP, (t < 0) ? CH_MIN : CH_PLUS,
                    ascii_digit(mag / 10), ascii_digit(mag % 10)}, 4, ST_OK);
      end else begin
        push_code(CH_UNK, ST_UNK);
      end
    end
  endtask

  task automatic track_rx_byte(input in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    if (!frame_open) begin
      if (b == CH_SOF) begin
        frame_open = 1'b1;
        frame_len  = 0;
        body_sum   = '0;
      end
    end else if (b == CH_EOF) begin
      close_frame(it.sensor_temp);
    end else if (frame_len >= MAX_FRAME - 2) begin
      frame_open = 1'b0;
      push_code(CH_FRM, ST_FRAME);
    end else begin
      if (frame_len >= 3) body_sum += tail_bytes[0];
      tail_bytes[0] = tail_bytes[1];
      tail_bytes[1] = tail_bytes[2];
      tail_bytes[2] = b;
      if (frame_len < 4) lead_bytes[frame_len] = b;
      frame_len++;
    end
  endtask

  // stimulus helpers
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_but_close();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == CH_EOF) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] pick_temp();
    if ($urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 6))
        0:       return 8'(127);
        1:       return 8'(-128);
        2:       return 8'(0);
        3:       return 8'(99);
        4:       return 8'(-99);
        5:       return 8'(100);
        default: return 8'(-100);
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic [7:0] temp);
    in_item_t it;
    it.rx_byte     = b;
    it.sensor_temp = temp;
    request_q.push_back(it);
  endtask

  task automatic add_digits(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) body_q.push_back(ascii_digit(9));
      else body_q.push_back(ascii_digit($urandom_range(0, 9)));
    end
  endtask

  task automatic add_noise(input int n);
    repeat (n) body_q.push_back(any_but_close());
  endtask

  task automatic build_body(input cmd_kind_t kind);
    case (kind)
      CMD_MAX: begin
        body_q.push_back(CH_MAX);
        add_digits($urandom_range(0, 4));
        add_noise($urandom_range(0, 2));
      end
      CMD_BAND: begin
        body_q.push_back(CH_BAND);
        add_digits($urandom_range(0, 3));
        add_noise($urandom_range(0, 2));
      end
      CMD_TEMP: begin
        body_q.push_back(CH_CUR);
        add_noise($urandom_range(0, 3));
      end
      CMD_OTHER: add_noise($urandom_range(1, 6));
      default: ;
    endcase
  endtask

  // '#', body, three sum digits (one spoiled if corrupt), '!'
  task automatic queue_frame(input bit corrupt, input logic [7:0] close_temp);
    logic [7:0] sum;
    logic [7:0] digs [3];
    logic [7:0] b;
    int         k;
    sum = '0;
    queue_byte(CH_SOF, 8'($urandom));
    foreach (body_q[i]) begin
      queue_byte(body_q[i], 8'($urandom));
      sum += body_q[i];
    end
    digs[0] = ascii_digit(sum / 100);
    digs[1] = ascii_digit((sum / 10) % 10);
    digs[2] = ascii_digit(sum % 10);
    if (corrupt) begin
      k = $urandom_range(0, 2);
      do b = any_but_close(); while (b == digs[k]);
      digs[k] = b;
    end
    for (k = 0; k < 3; k++) queue_byte(digs[k], 8'($urandom));
    queue_byte(CH_EOF, close_temp);
    frame_bytes += body_q.size() + 5;
    body_q.delete();
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_took) begin
      if (rx_gap > 0) begin
        rx_valid <= 1'b0;
        rx_gap--;
      end else if (request_q.size() > 0) begin
        rx_valid <= 1'b1;
        rx_data  <= request_q.pop_front();
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = rx_calm ? 0 : idle_len();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // reply side backpressure
  always @(negedge clk) begin
    if (rst) begin
      tx_ready <= 1'b0;
    end else if (tx_stall > 0) begin
      tx_ready <= 1'b0;
      tx_stall--;
    end else begin
      tx_ready <= 1'b1;
      if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
      if (!tx_calm && $urandom_range(0, 99) < 20) tx_stall = idle_len();
    end
  end

  // checking and prediction
  always @(posedge clk) begin
    out_item_t exp_item;
    cycle_count++;
    rx_took <= rx_valid && rx_ready;
    if (!rst) begin
      if (tx_valid && tx_ready) begin
        if (reply_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply byte %h (last %b status %0d)", $time,
                   tx_data.tx_byte, tx_data.last, tx_data.reply_status);
        end else begin
          exp_item = reply_bytes_q.pop_front();
          if (tx_data !== exp_item) begin
            errors++;
            $display("%0t: reply expected %h/%b/%0d/%0d/%0d got %h/%b/%0d/%0d/%0d",
                     $time, exp_item.tx_byte, exp_item.last, exp_item.reply_status,
                     exp_item.temp_limit, exp_item.half_band, tx_data.tx_byte,
                     tx_data.last, tx_data.reply_status, tx_data.temp_limit,
                     tx_data.half_band);
          end
        end
      end
      if (rx_valid && rx_ready) begin
        track_rx_byte(rx_data);
        rx_count++;
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int        pick;
    int        r;
    int        n;
    cmd_kind_t kind;

    // directed: stray bytes, max settings, hash in payload with lowest
    // temperature, empty payload, frame with nothing before '!'
    queue_byte(8'hFF, 8'h7F);
    queue_byte(8'h00, 8'h80);
    body_q.push_back(CH_MAX);
    add_noise(0);
    repeat (3) body_q.push_back(ascii_digit(9));
    queue_frame(1'b0, 8'h00);
    body_q.push_back(CH_CUR);
    body_q.push_back(CH_SOF);
    queue_frame(1'b0, 8'h80);
    queue_frame(1'b0, 8'h7F);
    queue_byte(CH_SOF, 8'h55);
    queue_byte(CH_EOF, 8'hAA);

    while (frame_bytes < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        r = $urandom_range(0, 99);
        kind = (r < 25) ? CMD_MAX : (r < 45) ? CMD_BAND : (r < 70) ? CMD_TEMP :
               (r < 90) ? CMD_OTHER : CMD_EMPTY;
        build_body(kind);
        queue_frame(1'b0, pick_temp());
      end else if (pick < 77) begin
        build_body(cmd_kind_t'($urandom_range(0, 4)));
        queue_frame(1'b1, pick_temp());
      end else if (pick < 82) begin
        n = $urandom_range(0, 2);
        queue_byte(CH_SOF, 8'($urandom));
        repeat (n) queue_byte(any_but_close(), 8'($urandom));
        queue_byte(CH_EOF, 8'($urandom));
        frame_bytes += n + 2;
      end else if (pick < 87) begin
        // overlong, then trailing bytes that must be dropped
        n = $urandom_range(15, 18);
        queue_byte(CH_SOF, 8'($urandom));
        repeat (n) queue_byte(any_but_close(), 8'($urandom));
        if ($urandom_range(0, 1)) queue_byte(CH_EOF, 8'($urandom));
        frame_bytes += 16;
      end else if (pick < 93) begin
        // frames one byte under the length limit, at it, and one byte past it
        add_noise($urandom_range(10, 12));
        queue_frame($urandom_range(0, 3) == 0, pick_temp());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          r = $urandom;
          queue_byte((8'(r) == CH_SOF) ? CH_EOF : 8'(r), 8'($urandom));
        end
      end
    end
    request_total = request_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (rx_count == request_total);
    wait (reply_bytes_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && reply_bytes_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
